// ===== hdl/wsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfp_pkg
// types and constants for the websocket frame header parser
// ----------------------------------------------------------------------------
package wsfp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} wsfp_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] frame_len;
		logic [31:0] mask_key;
		logic [7:0]  payload_data;
		logic        last;
	} wsfp_out_t;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD,
		PH_SKIP
	} wsfp_phase_t;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [6:0] LEN_EXT16 = 7'd126;

	localparam logic [3:0] HC_EXT16 = 4'd2;
	localparam logic [3:0] HC_EXT64 = 4'd8;
	localparam logic [3:0] HC_KEY   = 4'd4;

endpackage

// ===== hdl/websocket_frame_parser.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_parser: one byte per beat in, header/payload/error beats out
// input register, then two-entry result queue; 1 byte/cycle unless stalled
// input stalls while the result queue has no room for the byte's result beats
// reset clears control state; parser then awaits the first header byte
// ----------------------------------------------------------------------------
module websocket_frame_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wsfp_pkg::wsfp_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wsfp_pkg::wsfp_out_t  out_data
);

	// input stage
	logic                 in_v_s1;
	wsfp_pkg::wsfp_in_t   in_s1;

	// parser state
	wsfp_pkg::wsfp_phase_t phase_q, phase_d;
	logic [3:0]  hc_q, hc_d;
	logic        fin_q, fin_d;
	logic [2:0]  rsv_q, rsv_d;
	logic [3:0]  op_q, op_d;
	logic        mask_q, mask_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  kp_q, kp_d;

	// events of the byte in the input stage
	logic        hdr_ev, pay_ev, err_ev, pay_last;
	logic [7:0]  pay_byte;

	// result queue
	wsfp_pkg::wsfp_out_t slot0_q, slot1_q, slot0_d, slot1_d, r0, r1;
	logic [1:0]  cnt_q, cnt_d, base, avail, n_res;
	logic        pop, fire;

	// next state
	always_comb begin
		logic [7:0] b;
		logic [7:0] kb;
		b        = in_s1.data_byte;
		kb       = '0;
		phase_d  = phase_q;
		hc_d     = hc_q;
		fin_d    = fin_q;
		rsv_d    = rsv_q;
		op_d     = op_q;
		mask_d   = mask_q;
		len_d    = len_q;
		key_d    = key_q;
		rem_d    = rem_q;
		kp_d     = kp_q;
		hdr_ev   = 1'b0;
		pay_ev   = 1'b0;
		err_ev   = 1'b0;
		pay_last = 1'b0;
		pay_byte = '0;
		case (phase_q)
			wsfp_pkg::PH_FIRST: begin
				fin_d   = b[7];
				rsv_d   = b[6:4];
				op_d    = b[3:0];
				mask_d  = 1'b0;
				len_d   = '0;
				key_d   = '0;
				hc_d    = '0;
				phase_d = wsfp_pkg::PH_SECOND;
			end
			wsfp_pkg::PH_SECOND: begin
				mask_d = b[7];
				if (b[6:0] < wsfp_pkg::LEN_EXT16) begin
					len_d = {57'd0, b[6:0]};
					if (b[7]) begin
						hc_d    = wsfp_pkg::HC_KEY;
						phase_d = wsfp_pkg::PH_KEY;
					end else begin
						hdr_ev = 1'b1;
					end
				end else begin
					len_d   = '0;
					hc_d    = (b[6:0] == wsfp_pkg::LEN_EXT16) ? wsfp_pkg::HC_EXT16
					                                          : wsfp_pkg::HC_EXT64;
					phase_d = wsfp_pkg::PH_EXTLEN;
				end
			end
			wsfp_pkg::PH_EXTLEN: begin
				len_d = {len_q[55:0], b};
				hc_d  = hc_q - 4'd1;
				if (hc_d == 4'd0) begin
					if (mask_q) begin
						hc_d    = wsfp_pkg::HC_KEY;
						phase_d = wsfp_pkg::PH_KEY;
					end else begin
						hdr_ev = 1'b1;
					end
				end
			end
			wsfp_pkg::PH_KEY: begin
				key_d = {key_q[23:0], b};
				hc_d  = hc_q - 4'd1;
				if (hc_d == 4'd0) begin
					hdr_ev = 1'b1;
				end
			end
			wsfp_pkg::PH_PAYLOAD: begin
				case (kp_q)
					2'd0:    kb = key_q[31:24];
					2'd1:    kb = key_q[23:16];
					2'd2:    kb = key_q[15:8];
					default: kb = key_q[7:0];
				endcase
				pay_ev   = 1'b1;
				pay_byte = mask_q ? (b ^ kb) : b;
				kp_d     = kp_q + 2'd1;
				rem_d    = rem_q - 64'd1;
				pay_last = (rem_d == 64'd0);
				if (pay_last) begin
					phase_d = wsfp_pkg::PH_SKIP;
				end
			end
			default: begin
				phase_d = wsfp_pkg::PH_SKIP;
			end
		endcase
		if (hdr_ev) begin
			rem_d   = len_d;
			kp_d    = '0;
			phase_d = (len_d == 64'd0) ? wsfp_pkg::PH_SKIP : wsfp_pkg::PH_PAYLOAD;
		end
		if (in_s1.end_of_buffer) begin
			err_ev  = (phase_d != wsfp_pkg::PH_SKIP) && (phase_d != wsfp_pkg::PH_FIRST);
			phase_d = wsfp_pkg::PH_FIRST;
			hc_d    = '0;
		end
	end

	// result beats
	always_comb begin
		r0 = '0;
		r1 = '0;
		if (hdr_ev) begin
			r0.kind      = wsfp_pkg::KIND_HEADER;
			r0.fin       = fin_d;
			r0.rsv       = rsv_d;
			r0.opcode    = op_d;
			r0.masked    = mask_d;
			r0.frame_len = len_d;
			r0.mask_key  = key_d;
			r0.last      = (len_d == 64'd0);
		end else if (pay_ev) begin
			r0.kind         = wsfp_pkg::KIND_PAYLOAD;
			r0.payload_data = pay_byte;
			r0.last         = pay_last;
		end else if (err_ev) begin
			r0.kind = wsfp_pkg::KIND_ERROR;
			r0.last = 1'b1;
		end
		r1.kind = wsfp_pkg::KIND_ERROR;
		r1.last = 1'b1;
		n_res   = {1'b0, hdr_ev | pay_ev} + {1'b0, err_ev};
	end

	// queue control
	always_comb begin
		pop     = out_valid && out_ready;
		base    = cnt_q - {1'b0, pop};
		avail   = 2'd2 - base;
		fire    = in_v_s1 && (n_res <= avail);
		in_ready = !in_v_s1 || fire;
		slot0_d = pop ? slot1_q : slot0_q;
		slot1_d = slot1_q;
		cnt_d   = base;
		if (fire) begin
			cnt_d = base + n_res;
			if (base == 2'd0) begin
				if (n_res != 2'd0) begin
					slot0_d = r0;
				end
				if (n_res == 2'd2) begin
					slot1_d = r1;
				end
			end else if (n_res != 2'd0) begin
				slot1_d = r0;
			end
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
			phase_q <= wsfp_pkg::PH_FIRST;
			hc_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (in_ready) begin
				in_v_s1 <= in_valid;
			end
			if (fire) begin
				phase_q <= phase_d;
				hc_q    <= hc_d;
			end
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		if (fire) begin
			fin_q  <= fin_d;
			rsv_q  <= rsv_d;
			op_q   <= op_d;
			mask_q <= mask_d;
			len_q  <= len_d;
			key_q  <= key_d;
			rem_q  <= rem_d;
			kp_q   <= kp_d;
		end
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	// error beats always close the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == wsfp_pkg::KIND_ERROR) |-> out_data.last)
		else $error("error beat without last");

	// a byte with the end mark returns the parser to the first header byte
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_s1.end_of_buffer |=> phase_q == wsfp_pkg::PH_FIRST)
		else $error("end of buffer did not restart parsing");

	// unmasked header carries a zero key
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == wsfp_pkg::KIND_HEADER) && !out_data.masked
		|-> out_data.mask_key == 32'd0)
		else $error("unmasked header with nonzero key");

	// the result queue never holds more than two beats
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overflow");

endmodule
